>>> rtl/core/uertm_pkg.sv
// Shared types and constants for the ultrasonic echo ranging trimmed mean unit.
// No dependencies; imported by the result interface, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package uertm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned TB_W      = 64;
  localparam int unsigned DVS_W     = 24;
  localparam int unsigned DIV_CNT_W = $clog2(TB_W);
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SENSOR_READY  = 3'd0,
    REG_TRIGGER_TICKS = 3'd1,
    REG_PERIOD_TICKS  = 3'd2,
    REG_TICKS_PER_US  = 3'd3,
    REG_US_PER_CM     = 3'd4
  } reg_idx_e;

  localparam logic        RST_SENSOR_READY  = 1'b0;
  localparam logic [15:0] RST_TRIGGER_TICKS = 16'd4800;
  localparam logic [31:0] RST_PERIOD_TICKS  = 32'd40000000;
  localparam logic [15:0] RST_TICKS_PER_US  = 16'd400;
  localparam logic [7:0]  RST_US_PER_CM     = 8'd58;

endpackage

`default_nettype wire

>>> rtl/core/uertm_if.sv
// Valid/ready channel interfaces for input ticks and result items.
// Depends on uertm_pkg for the distance width.
`timescale 1ns / 1ps
`default_nettype none

interface uertm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uertm_out_if
  import uertm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              busy_res;
  logic              done_res;
  logic              error;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, output trigger, output busy_res, output done_res,
                  output error, output distance_cm, input ready);
  modport sink   (input valid, input trigger, input busy_res, input done_res,
                  input error, input distance_cm, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ultrasonic_echo_ranging_trimmed_mean_unit.sv
// Channel    Dir  Handshake          Payload
// in_i       in   valid/ready        start_req, echo (one time-base tick)
// out_o      out  valid/ready        trigger, busy_res, done_res, error, distance_cm
// apb        in   psel/penable/pwrite sensor_ready, trigger_ticks, period_ticks,
//                                    ticks_per_us, us_per_cm at byte address 4*i
//
// A sample-read tick runs 64 steps of the shared restoring divider (one quotient bit
// per cycle) plus load and accumulate. On the final sample tick the largest and smallest
// samples are subtracted and a second 64-step pass divides by KEPT_SAMPLES. Reset is
// asynchronous, active low; no clearing pass. in_i stalls outside its tick state
// (divider, accumulate, trim, done) or while an unaccepted result sits in out_o.
// Depends on uertm_pkg and uertm_if.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranging_trimmed_mean_unit
  import uertm_pkg::*;
#(
  parameter int unsigned KEPT_SAMPLES = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  uertm_in_if.sink               in_i,
  uertm_out_if.source            out_o
);

  localparam int unsigned NSAMP = KEPT_SAMPLES + 2;
  localparam int unsigned CNT_W = $clog2(NSAMP);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    ST_TICK,
    ST_DIV,
    ST_ACC,
    ST_TRIM,
    ST_TRIM2,
    ST_AVG,
    ST_DONE
  } state_e;

  // configuration
  logic        sensor_ready_q;
  logic [15:0] trigger_ticks_q;
  logic [31:0] period_ticks_q;
  logic [15:0] ticks_per_us_q;
  logic [7:0]  us_per_cm_q;

  // control and model state
  state_e               st_q, st_d;
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [31:0]          pticks_q, pticks_d;
  logic [TB_W-1:0]      tb_q, tb_d;
  logic                 echo_prev_q, echo_prev_d;
  logic [TB_W-1:0]      begin_q, begin_d;
  logic [TB_W-1:0]      end_q, end_d;
  logic [TB_W-1:0]      sum_q, sum_d;
  logic [TB_W-1:0]      large_q, large_d;
  logic [TB_W-1:0]      small_q, small_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ovalid_q, ovalid_d;

  // datapath
  logic [TB_W-1:0]   quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic              otrig_q, otrig_d;
  logic              obusy_q, obusy_d;
  logic              odone_q, odone_d;
  logic              oerr_q, oerr_d;
  logic [DIST_W-1:0] odist_q, odist_d;

  logic              cfg_wr;
  reg_idx_e          cfg_idx;
  logic              in_fire;
  logic [15:0]       tlen;
  logic [31:0]       plen;
  logic [15:0]       dv1;
  logic [7:0]        dv2;
  logic [DVS_W:0]    trial;
  logic              ge;
  logic [DVS_W-1:0]  rem_step;
  logic [TB_W-1:0]   quo_step;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SENSOR_READY:  prdata = {31'b0, sensor_ready_q};
      REG_TRIGGER_TICKS: prdata = {16'b0, trigger_ticks_q};
      REG_PERIOD_TICKS:  prdata = period_ticks_q;
      REG_TICKS_PER_US:  prdata = {16'b0, ticks_per_us_q};
      REG_US_PER_CM:     prdata = {24'b0, us_per_cm_q};
      default:           prdata = '0;
    endcase
  end

  assign in_i.ready        = (st_q == ST_TICK) && (!ovalid_q || out_o.ready);
  assign in_fire           = in_i.valid && in_i.ready;
  assign out_o.valid       = ovalid_q;
  assign out_o.trigger     = otrig_q;
  assign out_o.busy_res    = obusy_q;
  assign out_o.done_res    = odone_q;
  assign out_o.error       = oerr_q;
  assign out_o.distance_cm = odist_q;

  assign tlen = (trigger_ticks_q == 16'd0) ? 16'd1 : trigger_ticks_q;
  assign plen = (period_ticks_q == 32'd0) ? 32'd1 : period_ticks_q;
  assign dv1  = (ticks_per_us_q == 16'd0) ? 16'd1 : ticks_per_us_q;
  assign dv2  = (us_per_cm_q == 8'd0) ? 8'd1 : us_per_cm_q;

  // one restoring division step
  assign trial    = {rem_q, quo_q[TB_W-1]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign rem_step = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
  assign quo_step = {quo_q[TB_W-2:0], ge};

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    pticks_d    = pticks_q;
    tb_d        = tb_q;
    echo_prev_d = echo_prev_q;
    begin_d     = begin_q;
    end_d       = end_q;
    sum_d       = sum_q;
    large_d     = large_q;
    small_d     = small_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    otrig_d     = otrig_q;
    obusy_d     = obusy_q;
    odone_d     = odone_q;
    oerr_d      = oerr_q;
    odist_d     = odist_q;
    ovalid_d    = ovalid_q && !out_o.ready;

    unique case (st_q)
      ST_TICK: begin
        if (in_fire) begin
          if (in_i.echo && !echo_prev_q) begin
            begin_d = tb_q;
          end
          if (!in_i.echo && echo_prev_q) begin
            end_d = tb_q;
          end
          echo_prev_d = in_i.echo;
          tb_d        = tb_q + TB_W'(1);
          otrig_d     = 1'b0;
          obusy_d     = 1'b0;
          odone_d     = 1'b0;
          oerr_d      = 1'b0;
          odist_d     = '0;
          ovalid_d    = 1'b1;
          unique case (phase_q)
            PH_IDLE: begin
              if (in_i.start_req) begin
                if (!sensor_ready_q) begin
                  oerr_d = 1'b1;
                end else begin
                  phase_d  = PH_TRIG;
                  pticks_d = 32'd1;
                  idx_d    = '0;
                  sum_d    = '0;
                  large_d  = '0;
                  small_d  = '1;
                  otrig_d  = 1'b1;
                  obusy_d  = 1'b1;
                end
              end
            end
            PH_TRIG: begin
              obusy_d = 1'b1;
              if (pticks_q >= {16'b0, tlen}) begin
                phase_d  = PH_WAIT;
                pticks_d = 32'd1;
              end else begin
                pticks_d = pticks_q + 32'd1;
                otrig_d  = 1'b1;
              end
            end
            PH_WAIT: begin
              obusy_d = 1'b1;
              if (pticks_q >= plen) begin
                // hold the result back until the divider finishes
                ovalid_d = 1'b0;
                quo_d    = end_d - begin_d;
                rem_d    = '0;
                dvs_d    = {8'b0, dv1} * {16'b0, dv2};
                cnt_d    = '1;
                st_d     = ST_DIV;
              end else begin
                pticks_d = pticks_q + 32'd1;
              end
            end
            default: begin
              phase_d  = PH_IDLE;
              pticks_d = '0;
            end
          endcase
        end
      end
      ST_DIV, ST_AVG: begin
        quo_d = quo_step;
        rem_d = rem_step;
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          st_d = (st_q == ST_DIV) ? ST_ACC : ST_DONE;
        end
      end
      ST_ACC: begin
        sum_d = sum_q + quo_q;
        if (quo_q > large_q) begin
          large_d = quo_q;
        end
        if (quo_q < small_q) begin
          small_d = quo_q;
        end
        if (idx_q == CNT_W'(NSAMP - 1)) begin
          st_d = ST_TRIM;
        end else begin
          idx_d    = idx_q + CNT_W'(1);
          phase_d  = PH_TRIG;
          pticks_d = 32'd1;
          otrig_d  = 1'b1;
          obusy_d  = 1'b1;
          ovalid_d = 1'b1;
          st_d     = ST_TICK;
        end
      end
      ST_TRIM: begin
        quo_d = sum_q - large_q;
        st_d  = ST_TRIM2;
      end
      ST_TRIM2: begin
        quo_d = quo_q - small_q;
        rem_d = '0;
        dvs_d = DVS_W'(KEPT_SAMPLES);
        cnt_d = '1;
        st_d  = ST_AVG;
      end
      ST_DONE: begin
        odist_d  = (|quo_q[TB_W-1:DIST_W]) ? '1 : quo_q[DIST_W-1:0];
        otrig_d  = 1'b0;
        obusy_d  = 1'b0;
        odone_d  = 1'b1;
        oerr_d   = 1'b0;
        ovalid_d = 1'b1;
        phase_d  = PH_IDLE;
        pticks_d = '0;
        idx_d    = '0;
        st_d     = ST_TICK;
      end
      default: begin
        st_d = ST_TICK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_ready_q  <= RST_SENSOR_READY;
      trigger_ticks_q <= RST_TRIGGER_TICKS;
      period_ticks_q  <= RST_PERIOD_TICKS;
      ticks_per_us_q  <= RST_TICKS_PER_US;
      us_per_cm_q     <= RST_US_PER_CM;
      st_q            <= ST_TICK;
      phase_q         <= PH_IDLE;
      idx_q           <= '0;
      pticks_q        <= '0;
      tb_q            <= '0;
      echo_prev_q     <= 1'b0;
      begin_q         <= '0;
      end_q           <= '0;
      sum_q           <= '0;
      large_q         <= '0;
      small_q         <= '1;
      cnt_q           <= '0;
      ovalid_q        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SENSOR_READY:  sensor_ready_q  <= pwdata[0];
          REG_TRIGGER_TICKS: trigger_ticks_q <= pwdata[15:0];
          REG_PERIOD_TICKS:  period_ticks_q  <= pwdata;
          REG_TICKS_PER_US:  ticks_per_us_q  <= pwdata[15:0];
          REG_US_PER_CM:     us_per_cm_q     <= pwdata[7:0];
          default: ;
        endcase
      end
      st_q        <= st_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      pticks_q    <= pticks_d;
      tb_q        <= tb_d;
      echo_prev_q <= echo_prev_d;
      begin_q     <= begin_d;
      end_q       <= end_d;
      sum_q       <= sum_d;
      large_q     <= large_d;
      small_q     <= small_d;
      cnt_q       <= cnt_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    otrig_q <= otrig_d;
    obusy_q <= obusy_d;
    odone_q <= odone_d;
    oerr_q  <= oerr_d;
    odist_q <= odist_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/uertm_checker.sv
// Port-level checks on the result channel of the ranging unit, bound to the top level.
// Depends on uertm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uertm_checker
  import uertm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic              trigger_i,
  input wire logic              busy_res_i,
  input wire logic              done_res_i,
  input wire logic              error_i,
  input wire logic [DIST_W-1:0] distance_cm_i
);

  // done ends the measurement: no trigger, not busy, no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> !busy_res_i && !trigger_i && !error_i)
    else $error("done item shows busy, trigger or error");

  // error leaves the unit idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i |-> !busy_res_i && !trigger_i)
    else $error("error item shows activity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && trigger_i |-> busy_res_i)
    else $error("trigger without busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !done_res_i |-> distance_cm_i == '0)
    else $error("distance nonzero without done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_cm_i)
      && $stable(done_res_i) && $stable(busy_res_i))
    else $error("stalled item dropped or changed");

endmodule

bind ultrasonic_echo_ranging_trimmed_mean_unit uertm_checker u_uertm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .trigger_i     (out_o.trigger),
  .busy_res_i    (out_o.busy_res),
  .done_res_i    (out_o.done_res),
  .error_i       (out_o.error),
  .distance_cm_i (out_o.distance_cm)
);

`default_nettype wire
